// File: hdl/ltd_pkg.sv
// Shared types and constants for the livetime packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package ltd_pkg;

    localparam int NUM_CHANNELS = 12;
    localparam int STEP_W       = 4;
    localparam int CHAN_W       = 4;
    localparam int HDR_POS_W    = 5;
    localparam int REC_POS_W    = 2;

    localparam logic [15:0] SYNC_WORD_RESET   = 16'hEB90;
    localparam logic [7:0]  PACKET_TYPE_RESET = 8'h06;

    // Configuration register indexes
    localparam logic CFG_SYNC_WORD   = 1'b0;
    localparam logic CFG_PACKET_TYPE = 1'b1;

    // Header byte positions (the type byte is position 2)
    localparam logic [HDR_POS_W-1:0] POS_FIRST      = 5'd3;
    localparam logic [HDR_POS_W-1:0] POS_TIME_LAST  = 5'd5;
    localparam logic [HDR_POS_W-1:0] POS_CNT_LAST   = 5'd7;
    localparam logic [HDR_POS_W-1:0] POS_SIZE_LAST  = 5'd9;
    localparam logic [HDR_POS_W-1:0] POS_CLOCK_LAST = 5'd15;
    localparam logic [HDR_POS_W-1:0] POS_MASK_HI    = 5'd16;
    localparam logic [HDR_POS_W-1:0] POS_MASK_LO    = 5'd17;

    localparam logic [REC_POS_W-1:0] REC_POS_LAST = 2'd3;
    localparam logic [STEP_W-1:0]    STEP_LAST    = 4'd11;

    // Channel walk: 8, 9, 10, 11, then 0 to 7
    localparam logic [CHAN_W-1:0] WALK_ORDER [NUM_CHANNELS] = '{
        4'd8, 4'd9, 4'd10, 4'd11, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7
    };

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_HEADER,
        ST_RECORD,
        ST_WALK
    } ltd_state_t;

    typedef struct packed {
        logic start_packet;
        logic hunt_shift;
        logic hdr_capture;
        logic rec_capture;
        logic rec_clear;
        logic emit_present;
        logic emit_absent;
        logic go_hunt;
    } ltd_cmd_t;

    typedef struct packed {
        logic hist_match;
        logic hdr_last;
        logic rec_last;
        logic step_last;
        logic chan_present;
        logic out_free;
    } ltd_status_t;

endpackage

`default_nettype wire

// File: hdl/ltd_ctrl.sv
// Packet sequencing state machine of the livetime deframer.
`timescale 1ns / 1ps
`default_nettype none

module ltd_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  ltd_pkg::ltd_status_t status,
    output ltd_pkg::ltd_cmd_t    cmd
);
    import ltd_pkg::*;

    ltd_state_t state_reg;
    ltd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b0;
        case (state_reg)
            ST_HUNT:
            begin
                if (in_valid)
                begin
                    if (status.hist_match)
                    begin
                        cmd.start_packet = 1'b1;
                        state_next       = ST_HEADER;
                    end
                    else
                    begin
                        cmd.hunt_shift = 1'b1;
                    end
                end
            end
            ST_HEADER:
            begin
                if (in_valid)
                begin
                    cmd.hdr_capture = 1'b1;
                    if (status.hdr_last)
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_RECORD:
            begin
                // The fourth byte of a record needs the output register.
                in_stall = status.rec_last && !status.out_free;
                if (in_valid && !in_stall)
                begin
                    if (status.rec_last)
                    begin
                        cmd.emit_present = 1'b1;
                        if (status.step_last)
                        begin
                            cmd.go_hunt = 1'b1;
                            state_next  = ST_HUNT;
                        end
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    else
                    begin
                        cmd.rec_capture = 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                in_stall = 1'b1;
                if (status.chan_present)
                begin
                    cmd.rec_clear = 1'b1;
                    state_next    = ST_RECORD;
                end
                else if (status.out_free)
                begin
                    cmd.emit_absent = 1'b1;
                    if (status.step_last)
                    begin
                        cmd.go_hunt = 1'b1;
                        state_next  = ST_HUNT;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/ltd_datapath.sv
// Sync history, header capture, record assembly and output register.
`timescale 1ns / 1ps
`default_nettype none

module ltd_datapath (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire                   cfg_index,
    input  wire  [15:0]           cfg_data,
    input  wire  [7:0]            data_byte,
    input  ltd_pkg::ltd_cmd_t     cmd,
    output ltd_pkg::ltd_status_t  status,
    output logic                  out_valid,
    input  wire                   out_stall,
    output logic [3:0]            channel,
    output logic                  present,
    output logic [15:0]           total_livetime,
    output logic [15:0]           shield_livetime,
    output logic [15:0]           seq_counter,
    output logic [23:0]           unix_time,
    output logic [15:0]           packet_size,
    output logic [47:0]           clock_value,
    output logic                  last
);
    import ltd_pkg::*;

    logic [15:0]           sync_word_reg;
    logic [7:0]            packet_type_reg;
    logic [15:0]           history_reg;
    logic [1:0]            hist_cnt_reg;
    logic [HDR_POS_W-1:0]  hdr_pos_reg;
    logic [REC_POS_W-1:0]  rec_pos_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [23:0]           hdr_time_reg;
    logic [15:0]           hdr_counter_reg;
    logic [15:0]           hdr_size_reg;
    logic [47:0]           hdr_clock_reg;
    logic [11:0]           mask_reg;
    logic [23:0]           record_reg;
    logic                  out_valid_reg;
    logic [3:0]            channel_reg;
    logic                  present_reg;
    logic [15:0]           total_reg;
    logic [15:0]           shield_reg;
    logic [15:0]           counter_reg;
    logic [23:0]           time_reg;
    logic [15:0]           size_reg;
    logic [47:0]           clock_reg;
    logic                  last_reg;
    logic [CHAN_W-1:0]     walk_chan;
    logic                  emit;

    assign walk_chan = WALK_ORDER[step_reg];
    assign emit      = cmd.emit_present || cmd.emit_absent;

    assign status.hist_match   = (hist_cnt_reg == 2'd2) && (history_reg == sync_word_reg)
                                 && (data_byte == packet_type_reg);
    assign status.hdr_last     = (hdr_pos_reg == POS_MASK_LO);
    assign status.rec_last     = (rec_pos_reg == REC_POS_LAST);
    assign status.step_last    = (step_reg == STEP_LAST);
    assign status.chan_present = mask_reg[walk_chan];
    assign status.out_free     = !out_valid_reg || !out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg   <= SYNC_WORD_RESET;
            packet_type_reg <= PACKET_TYPE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_WORD:   sync_word_reg   <= cfg_data;
                CFG_PACKET_TYPE: packet_type_reg <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // Control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg  <= '0;
            hist_cnt_reg <= '0;
            hdr_pos_reg  <= '0;
            rec_pos_reg  <= '0;
            step_reg     <= '0;
        end
        else
        begin
            if (cmd.go_hunt)
            begin
                history_reg  <= '0;
                hist_cnt_reg <= '0;
            end
            else if (cmd.hunt_shift)
            begin
                history_reg <= {history_reg[7:0], data_byte};
                if (hist_cnt_reg != 2'd2)
                begin
                    hist_cnt_reg <= hist_cnt_reg + 2'd1;
                end
            end
            if (cmd.start_packet)
            begin
                hdr_pos_reg <= POS_FIRST;
            end
            else if (cmd.hdr_capture)
            begin
                hdr_pos_reg <= hdr_pos_reg + 5'd1;
            end
            if (cmd.rec_clear)
            begin
                rec_pos_reg <= '0;
            end
            else if (cmd.rec_capture)
            begin
                rec_pos_reg <= rec_pos_reg + 2'd1;
            end
            if (cmd.hdr_capture && status.hdr_last)
            begin
                step_reg <= '0;
            end
            else if (emit)
            begin
                step_reg <= step_reg + 4'd1;
            end
        end
    end

    // Header fields and record bytes, shifted in big-endian
    always_ff @(posedge clk)
    begin
        if (cmd.hdr_capture)
        begin
            case (hdr_pos_reg) inside
                [POS_FIRST:POS_TIME_LAST]:
                    hdr_time_reg <= {hdr_time_reg[15:0], data_byte};
                [5'd6:POS_CNT_LAST]:
                    hdr_counter_reg <= {hdr_counter_reg[7:0], data_byte};
                [5'd8:POS_SIZE_LAST]:
                    hdr_size_reg <= {hdr_size_reg[7:0], data_byte};
                [5'd10:POS_CLOCK_LAST]:
                    hdr_clock_reg <= {hdr_clock_reg[39:0], data_byte};
                POS_MASK_HI:
                    mask_reg <= {data_byte[3:0], 8'h00};
                POS_MASK_LO:
                    mask_reg <= {mask_reg[11:8], data_byte};
                default:
                    ;
            endcase
        end
        if (cmd.rec_capture)
        begin
            record_reg <= {record_reg[15:0], data_byte};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            channel_reg <= walk_chan;
            present_reg <= cmd.emit_present;
            total_reg   <= cmd.emit_present ? record_reg[23:8] : 16'h0000;
            shield_reg  <= cmd.emit_present ? {record_reg[7:0], data_byte} : 16'h0000;
            counter_reg <= hdr_counter_reg;
            time_reg    <= hdr_time_reg;
            size_reg    <= hdr_size_reg;
            clock_reg   <= hdr_clock_reg;
            last_reg    <= status.step_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign channel         = channel_reg;
    assign present         = present_reg;
    assign total_livetime  = total_reg;
    assign shield_livetime = shield_reg;
    assign seq_counter     = counter_reg;
    assign unix_time       = time_reg;
    assign packet_size     = size_reg;
    assign clock_value     = clock_reg;
    assign last            = last_reg;

endmodule

`default_nettype wire

// File: hdl/livetime_packet_deframer_core.sv
// Top level of the livetime packet deframer: controller plus datapath.
// Throughput: one byte a cycle while hunting, in the header and in livetime records, but
// a record's fourth byte waits while the output is full and stalled. A present record is
// on the output in the cycle after its fourth byte is taken. After that byte or the mask
// byte, absent channels follow one a cycle while the output is free; the input stalls.
// Reset (rst_n, asynchronous): hunting, empty history, output empty, 0xEB90 and 0x06.
`timescale 1ns / 1ps
`default_nettype none

module livetime_packet_deframer_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [15:0] cfg_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [7:0]  data_byte,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [3:0]  channel,
    output logic        present,
    output logic [15:0] total_livetime,
    output logic [15:0] shield_livetime,
    output logic [15:0] seq_counter,
    output logic [23:0] unix_time,
    output logic [15:0] packet_size,
    output logic [47:0] clock_value,
    output logic        last
);
    import ltd_pkg::*;

    // Commands from the controller and status from the datapath are the only link
    // between the two halves.
    ltd_cmd_t    cmd;
    ltd_status_t status;

    // The controller tracks where in a packet the stream is and decides, for each
    // word, whether it feeds the sync history, the header or a livetime record.
    ltd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the history, header fields, mask and walk position, and the
    // output register, so a finished record can wait while further words arrive.
    ltd_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .data_byte       (data_byte),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .channel         (channel),
        .present         (present),
        .total_livetime  (total_livetime),
        .shield_livetime (shield_livetime),
        .seq_counter     (seq_counter),
        .unix_time       (unix_time),
        .packet_size     (packet_size),
        .clock_value     (clock_value),
        .last            (last)
    );

endmodule

`default_nettype wire
